// ===== rtl/core/sbe_pkg.sv =====
package sbe_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_OK    = 3'd0;
  localparam logic [2:0] KIND_VAL   = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_HALT  = 3'd3;
  localparam logic [2:0] KIND_FAULT = 3'd4;

  // Actions.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_EXEC  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Opcodes.
  localparam logic [31:0] OP_EXIT = 32'd0;
  localparam logic [31:0] OP_IMM  = 32'd1;
  localparam logic [31:0] OP_ADD  = 32'd2;
  localparam logic [31:0] OP_SUB  = 32'd3;
  localparam logic [31:0] OP_MUL  = 32'd4;
  localparam logic [31:0] OP_DIV  = 32'd5;
  localparam logic [31:0] OP_LT   = 32'd6;
  localparam logic [31:0] OP_GT   = 32'd7;
  localparam logic [31:0] OP_EQ   = 32'd8;
  localparam logic [31:0] OP_PRV  = 32'd9;
  localparam logic [31:0] OP_PRS  = 32'd10;
  localparam logic [31:0] OP_STO  = 32'd11;
  localparam logic [31:0] OP_LDV  = 32'd12;
  localparam logic [31:0] OP_JZ   = 32'd13;
  localparam logic [31:0] OP_JMP  = 32'd14;

  // ALU operations.
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_MUL = 3'd2,
    ALU_DIV = 3'd3,
    ALU_LT  = 3'd4,
    ALU_GT  = 3'd5,
    ALU_EQ  = 3'd6
  } alu_op_t;

  localparam logic [6:0] REG_STRING_COUNT = 7'd0;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] code_word;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } out_beat_t;

  // Sequencer to ALU request.
  typedef struct packed {
    logic       start;
    alu_op_t    op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

// ===== rtl/core/stack_bytecode_executor.sv =====
// Stack-machine bytecode executor. Each input beat is one action: load a
// code word, clear (a sweep over the VAR_COUNT variables in S_CLR), or
// execute one instruction. An execute reads the opcode and operand from
// program memory and up to two stack words in successive states (S_FOP,
// S_OP, S_ARG, S_RDB, S_RDA) before S_EXEC. It goes straight to the result
// when the machine is already halted or past the end of the program, and
// halts from S_ARG when an instruction's operand word lies past the end.
// A binary operation adds the ALU issue state and the wait for its result
// from the shared ALU, whose divider is a 32-step divider. The result beat
// waits in S_OUT while the output stalls.
// The block takes no new beat until the result beat has been delivered.
// Program and stack memories are not cleared; the pointers bound all reads.
module stack_bytecode_executor
  import sbe_pkg::*;
#(
  parameter int CODE_DEPTH   = 4096,
  parameter int STACK_DEPTH  = 1024,
  parameter int VAR_COUNT    = 26,
  parameter int STRING_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CAW = $clog2(CODE_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FOP   = 11'b00000000010,
    S_OP    = 11'b00000000100,
    S_ARG   = 11'b00000001000,
    S_RDB   = 11'b00000010000,
    S_RDA   = 11'b00000100000,
    S_EXEC  = 11'b00001000000,
    S_ALU   = 11'b00010000000,
    S_WAIT  = 11'b00100000000,
    S_CLR   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CAW:0] plen_r, plen_nxt;
  logic [CAW:0] ip_r, ip_nxt;
  logic [SAW:0] sp_r, sp_nxt;
  logic        halt_r, halt_nxt;
  logic [6:0]  scount_r;
  logic [31:0] vars_r [VAR_COUNT];
  logic [31:0] op_r, op_nxt, arg_r, arg_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] val_r, val_nxt;
  logic [VAW-1:0] clr_r, clr_nxt;

  // Memories.
  logic [31:0] pmem [CODE_DEPTH];
  logic [31:0] smem [STACK_DEPTH];
  logic [31:0] prd_r, srd_r;
  logic        pwe, swe;
  logic [CAW-1:0] pwa, pra;
  logic [SAW-1:0] swa, sra;
  logic [31:0] pwd, swd;

  logic        var_we;
  logic [VAW-1:0] var_wa;
  logic [31:0] var_wd;

  alu_req_t    areq;
  alu_rsp_t    arsp;
  alu_op_t     aop;

  logic        accept;
  logic        has_arg;
  logic [CAW:0] tgt;
  logic [31:0] lim;
  logic        arg_var_ok;

  sbe_alu u_alu (
    .clk (clk),
    .rst_n (rst_n),
    .req (areq),
    .a (a_r),
    .b (b_r),
    .rsp (arsp)
  );

  always_ff @(posedge clk) begin
    if (pwe) pmem[pwa] <= pwd;
    prd_r <= pmem[pra];
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swa] <= swd;
    srd_r <= smem[sra];
  end

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, scount_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scount_r <= 7'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STRING_COUNT[0])) begin
      scount_r <= pwdata[6:0];
    end
  end

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.kind  = kind_r;
  assign out_data.value = val_r;

  assign has_arg = (op_r == OP_IMM) || (op_r == OP_PRS) || (op_r == OP_STO) ||
                   (op_r == OP_LDV) || (op_r == OP_JZ) || (op_r == OP_JMP);
  assign tgt = (arg_r > 32'(CODE_DEPTH)) ? (CAW+1)'(CODE_DEPTH) : arg_r[CAW:0];
  assign lim = (32'(scount_r) < 32'(STRING_SLOTS)) ? 32'(scount_r) : 32'(STRING_SLOTS);
  assign arg_var_ok = (arg_r < 32'(VAR_COUNT));

  always_comb begin
    unique case (op_r[3:0])
      4'd2: aop = ALU_ADD;
      4'd3: aop = ALU_SUB;
      4'd4: aop = ALU_MUL;
      4'd5: aop = ALU_DIV;
      4'd6: aop = ALU_LT;
      4'd7: aop = ALU_GT;
      default: aop = ALU_EQ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    plen_nxt = plen_r;
    ip_nxt   = ip_r;
    sp_nxt   = sp_r;
    halt_nxt = halt_r;
    op_nxt   = op_r;
    arg_nxt  = arg_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    kind_nxt = kind_r;
    val_nxt  = val_r;
    clr_nxt  = clr_r;
    pwe = 1'b0; pwa = plen_r[CAW-1:0]; pwd = in_data.code_word;
    pra = ip_r[CAW-1:0];
    swe = 1'b0; swa = sp_r[SAW-1:0]; swd = arg_r;
    sra = sp_r[SAW-1:0] - SAW'(1);
    var_we = 1'b0; var_wa = arg_r[VAW-1:0]; var_wd = a_r;
    areq.start = 1'b0; areq.op = aop;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt = KIND_OK;
          val_nxt  = 32'd0;
          unique case (in_data.action)
            ACT_LOAD: begin
              if (plen_r >= (CAW+1)'(CODE_DEPTH)) begin
                kind_nxt = KIND_FAULT;
              end else begin
                pwe = 1'b1;
                plen_nxt = plen_r + 1'b1;
              end
              state_nxt = S_OUT;
            end
            ACT_EXEC: begin
              if (halt_r) begin
                kind_nxt = KIND_HALT; state_nxt = S_OUT;
              end else if (ip_r >= plen_r) begin
                halt_nxt = 1'b1; kind_nxt = KIND_HALT; state_nxt = S_OUT;
              end else begin
                state_nxt = S_FOP;
              end
            end
            ACT_CLEAR: begin
              plen_nxt = '0; ip_nxt = '0; sp_nxt = '0; halt_nxt = 1'b0;
              clr_nxt = '0; state_nxt = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        var_we = 1'b1; var_wa = clr_r; var_wd = 32'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == VAW'(VAR_COUNT - 1)) state_nxt = S_OUT;
      end
      S_FOP: begin
        // Opcode word has landed; start the operand read.
        op_nxt = prd_r;
        pra = ip_r[CAW-1:0] + CAW'(1);
        state_nxt = S_OP;
      end
      S_OP: begin
        arg_nxt = prd_r;
        state_nxt = S_ARG;
      end
      S_ARG: begin
        if (has_arg && (ip_r + 1'b1 >= plen_r)) begin
          halt_nxt = 1'b1; kind_nxt = KIND_HALT; state_nxt = S_OUT;
        end else begin
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        // Top of stack has landed; read the word below it.
        sra = sp_r[SAW-1:0] - SAW'(2);
        state_nxt = S_RDA;
        b_nxt = srd_r;
      end
      S_RDA: begin
        b_nxt = b_r;
        a_nxt = srd_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        if (op_r == OP_EXIT) begin
          halt_nxt = 1'b1; kind_nxt = KIND_HALT;
        end else if (op_r == OP_IMM || op_r == OP_LDV) begin
          if (sp_r >= (SAW+1)'(STACK_DEPTH) || (op_r == OP_LDV && !arg_var_ok)) begin
            halt_nxt = 1'b1; kind_nxt = KIND_FAULT;
          end else begin
            swe = 1'b1;
            swd = (op_r == OP_LDV) ? vars_r[arg_r[VAW-1:0]] : arg_r;
            sp_nxt = sp_r + 1'b1; ip_nxt = ip_r + 2'd2;
          end
        end else if (op_r >= OP_ADD && op_r <= OP_EQ) begin
          if (sp_r < (SAW+1)'(2)) begin
            halt_nxt = 1'b1; kind_nxt = KIND_FAULT;
          end else begin
            state_nxt = S_ALU;
          end
        end else if (op_r == OP_PRV) begin
          if (sp_r == '0) begin
            halt_nxt = 1'b1; kind_nxt = KIND_FAULT;
          end else begin
            sp_nxt = sp_r - 1'b1; ip_nxt = ip_r + 1'b1;
            kind_nxt = KIND_VAL; val_nxt = b_r;
          end
        end else if (op_r == OP_PRS) begin
          ip_nxt = ip_r + 2'd2;
          if (!arg_r[31] && arg_r < lim) begin
            kind_nxt = KIND_STR; val_nxt = arg_r;
          end
        end else if (op_r == OP_STO) begin
          if (sp_r == '0 || !arg_var_ok) begin
            halt_nxt = 1'b1; kind_nxt = KIND_FAULT;
          end else begin
            var_we = 1'b1; var_wd = b_r;
            sp_nxt = sp_r - 1'b1; ip_nxt = ip_r + 2'd2;
          end
        end else if (op_r == OP_JZ) begin
          if (sp_r == '0) begin
            halt_nxt = 1'b1; kind_nxt = KIND_FAULT;
          end else begin
            sp_nxt = sp_r - 1'b1;
            ip_nxt = (b_r == 32'd0) ? tgt : ip_r + 2'd2;
          end
        end else if (op_r == OP_JMP) begin
          ip_nxt = tgt;
        end else begin
          ip_nxt = ip_r + 1'b1;
        end
      end
      S_ALU: begin
        areq.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (arsp.done) begin
          swe = 1'b1; swa = sp_r[SAW-1:0] - SAW'(2); swd = arsp.result;
          sp_nxt = sp_r - 1'b1; ip_nxt = ip_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // S_RDB captures the top word into b and S_RDA the word below it into a,
  // so a and b are already in operand order for the ALU.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plen_r  <= '0;
      ip_r    <= '0;
      sp_r    <= '0;
      halt_r  <= 1'b0;
      clr_r   <= '0;
      for (int i = 0; i < VAR_COUNT; i++) vars_r[i] <= 32'd0;
    end else begin
      state_r <= state_nxt;
      plen_r  <= plen_nxt;
      ip_r    <= ip_nxt;
      sp_r    <= sp_nxt;
      halt_r  <= halt_nxt;
      clr_r   <= clr_nxt;
      if (var_we) vars_r[var_wa] <= var_wd;
    end
    op_r   <= op_nxt;
    arg_r  <= arg_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
  end

endmodule

// ===== rtl/core/sbe_alu.sv =====
// Shared arithmetic unit: add, sub and compares are computed on the request,
// multiply works in 16-bit halves and divide uses a 32-step restoring divider.
module sbe_alu
  import sbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_rsp_t    rsp
);

  logic        busy_r, busy_nxt;
  alu_op_t     op_r, op_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic        neg_r, neg_nxt;
  logic        zero_r, zero_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [32:0] trial;
  logic [31:0] rem_sh;

  // Control and datapath step.
  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    rem_sh   = {rem_r[30:0], quo_r[31]};
    trial    = {1'b0, rem_sh} - {1'b0, dsr_r};
    if (req.start) begin
      op_nxt = req.op;
      unique case (req.op)
        ALU_ADD: begin res_nxt = a + b; done_nxt = 1'b1; end
        ALU_SUB: begin res_nxt = a - b; done_nxt = 1'b1; end
        ALU_LT: begin
          res_nxt = {31'd0, $signed(a) < $signed(b)}; done_nxt = 1'b1;
        end
        ALU_GT: begin
          res_nxt = {31'd0, $signed(a) > $signed(b)}; done_nxt = 1'b1;
        end
        ALU_EQ: begin res_nxt = {31'd0, a == b}; done_nxt = 1'b1; end
        ALU_MUL: begin
          // Low partial product now, cross terms next cycle.
          acc_nxt  = a[15:0] * b[15:0];
          quo_nxt  = a;
          dsr_nxt  = b;
          busy_nxt = 1'b1;
        end
        default: begin
          neg_nxt  = a[31] ^ b[31];
          zero_nxt = (b == 32'd0);
          quo_nxt  = a[31] ? (32'd0 - a) : a;
          dsr_nxt  = b[31] ? (32'd0 - b) : b;
          rem_nxt  = 32'd0;
          cnt_nxt  = 6'd0;
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        res_nxt  = acc_r + {quo_r[15:0] * dsr_r[31:16] + quo_r[31:16] * dsr_r[15:0], 16'd0};
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        // One quotient bit per cycle.
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          if (zero_r) res_nxt = 32'd0;
          else res_nxt = neg_r ? (32'd0 - quo_nxt) : quo_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

// ===== test/stack_bytecode_executor_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the executor, predicts each result beat from the
// accepted input beats and compares them in order.
module stack_bytecode_executor_checker
  import sbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_beat_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_beat_t  out_data,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output int         fail_count,
  output int         pending_count,
  output int         result_count
);

  localparam int CODE_DEPTH   = 4096;
  localparam int STACK_DEPTH  = 1024;
  localparam int VAR_COUNT    = 26;
  localparam int STRING_SLOTS = 64;

  logic [31:0] prog_mem [CODE_DEPTH];
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] vars [VAR_COUNT];
  int unsigned prog_len, ip, sp;
  bit          halted;
  logic [6:0]  slot_count;
  out_beat_t   expected_beats [$];

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 0) return 0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic out_beat_t mk(logic [2:0] k, logic [31:0] v);
    out_beat_t r;
    r.kind = k;
    r.value = v;
    return r;
  endfunction

  function automatic out_beat_t run_instruction();
    logic [31:0] op, arg, a, b, r;
    int unsigned lim;
    bit has_arg;
    arg = 0;
    if (halted) return mk(KIND_HALT, 0);
    if (ip >= prog_len) begin
      halted = 1;
      return mk(KIND_HALT, 0);
    end
    op = prog_mem[ip];
    has_arg = op inside {OP_IMM, OP_PRS, OP_STO, OP_LDV, OP_JZ, OP_JMP};
    if (has_arg) begin
      if (ip + 1 >= prog_len) begin
        halted = 1;
        return mk(KIND_HALT, 0);
      end
      arg = prog_mem[ip + 1];
    end
    case (op)
      OP_EXIT: begin
        halted = 1;
        return mk(KIND_HALT, 0);
      end
      OP_IMM, OP_LDV: begin
        if (sp >= STACK_DEPTH || (op == OP_LDV && arg >= VAR_COUNT)) begin
          halted = 1;
          return mk(KIND_FAULT, 0);
        end
        if (op == OP_LDV) arg = vars[arg];
        stack_mem[sp] = arg;
        sp++;
        ip += 2;
        return mk(KIND_OK, 0);
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_EQ: begin
        if (sp < 2) begin
          halted = 1;
          return mk(KIND_FAULT, 0);
        end
        a = stack_mem[sp - 2];
        b = stack_mem[sp - 1];
        case (op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_DIV: r = div_trunc(a, b);
          OP_LT:  r = ($signed(a) < $signed(b)) ? 1 : 0;
          OP_GT:  r = ($signed(b) < $signed(a)) ? 1 : 0;
          default: r = (a == b) ? 1 : 0;
        endcase
        sp--;
        stack_mem[sp - 1] = r;
        ip += 1;
        return mk(KIND_OK, 0);
      end
      OP_PRV: begin
        if (sp < 1) begin
          halted = 1;
          return mk(KIND_FAULT, 0);
        end
        sp--;
        ip += 1;
        return mk(KIND_VAL, stack_mem[sp]);
      end
      OP_PRS: begin
        lim = (slot_count < STRING_SLOTS) ? slot_count : STRING_SLOTS;
        ip += 2;
        if (!arg[31] && arg < lim) return mk(KIND_STR, arg);
        return mk(KIND_OK, 0);
      end
      OP_STO: begin
        if (sp < 1 || arg >= VAR_COUNT) begin
          halted = 1;
          return mk(KIND_FAULT, 0);
        end
        sp--;
        vars[arg] = stack_mem[sp];
        ip += 2;
        return mk(KIND_OK, 0);
      end
      OP_JZ, OP_JMP: begin
        if (arg > CODE_DEPTH) arg = CODE_DEPTH;
        if (op == OP_JZ) begin
          if (sp < 1) begin
            halted = 1;
            return mk(KIND_FAULT, 0);
          end
          sp--;
          ip = (stack_mem[sp] == 0) ? arg : ip + 2;
        end else begin
          ip = arg;
        end
        return mk(KIND_OK, 0);
      end
      default: begin
        ip += 1;
        return mk(KIND_OK, 0);
      end
    endcase
  endfunction

  // Clears the machine state; the string count survives a clear.
  task automatic clear_machine();
    prog_len = 0;
    ip = 0;
    sp = 0;
    halted = 0;
    for (int i = 0; i < VAR_COUNT; i++) vars[i] = 0;
  endtask

  // Predict on accepted input beats and check accepted result beats.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      clear_machine();
      slot_count = 0;
      expected_beats.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (psel && penable && pwrite && paddr == 3'(REG_STRING_COUNT))
        slot_count = pwdata[6:0];
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat kind %0d value %0d", $time,
                   out_data.kind, out_data.value);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (want.kind !== out_data.kind || want.value !== out_data.value) begin
            $display("%0t: mismatch expected kind %0d value %0d, got kind %0d value %0d",
                     $time, want.kind, want.value, out_data.kind, out_data.value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.action)
          ACT_LOAD: begin
            if (prog_len >= CODE_DEPTH) expected_beats.push_back(mk(KIND_FAULT, 0));
            else begin
              prog_mem[prog_len] = in_data.code_word;
              prog_len++;
              expected_beats.push_back(mk(KIND_OK, 0));
            end
          end
          ACT_EXEC: expected_beats.push_back(run_instruction());
          ACT_CLEAR: begin
            clear_machine();
            expected_beats.push_back(mk(KIND_OK, 0));
          end
          default: ;
        endcase
      end
    end
    pending_count = expected_beats.size();
  end

endmodule

// ===== test/stack_bytecode_executor_tb.sv =====
`timescale 1ns / 1ps

// Drives load, execute and clear beats into the executor and reports the verdict.
module stack_bytecode_executor_tb;
  import sbe_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending_count, result_count;
  int          beats_sent;
  int          hold_cycles;
  bit          long_hold;

  stack_bytecode_executor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stack_bytecode_executor_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver stalls on its own pattern, with one long hold-off on request.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        hold_cycles++;
        if (hold_cycles >= 200) begin
          long_hold = 0;
          out_stall <= 0;
        end
      end else if (beats_sent < 600 || beats_sent > 1400) begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // Sends one beat and waits for it to be accepted.
  task automatic send_beat(logic [1:0] act, logic [31:0] word);
    in_valid <= 1;
    in_data.action <= act;
    in_data.code_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (beats_sent % 17 == 0 || $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_string_count(logic [31:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= 3'(REG_STRING_COUNT);
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic load_op(logic [31:0] op, logic [31:0] arg);
    send_beat(ACT_LOAD, op);
    if (op inside {OP_IMM, OP_PRS, OP_STO, OP_LDV, OP_JZ, OP_JMP})
      send_beat(ACT_LOAD, arg);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 1);
      2: return 32'hFFFFFFFF;
      3: return 32'h7FFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // A random program, loaded after a clear and then given n + 3 execute beats.
  task automatic random_program();
    int n, depth;
    logic [31:0] op;
    n = $urandom_range(3, 14);
    depth = 0;
    send_beat(ACT_CLEAR, $urandom);
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 20) == 0 ? $urandom_range(0, 15) :
           (depth < 2 ? OP_IMM : $urandom_range(1, 14));
      case (op)
        OP_IMM: begin load_op(op, rand_word()); depth++; end
        OP_STO, OP_LDV: begin
          load_op(op, $urandom_range(0, 30) == 0 ? $urandom : $urandom_range(0, 25));
          depth += (op == OP_LDV) ? 1 : -1;
        end
        OP_PRS: load_op(op, $urandom_range(0, 8) == 0 ? $urandom : $urandom_range(0, 70));
        OP_JZ, OP_JMP: begin
          load_op(op, $urandom_range(0, 10) == 0 ? $urandom : $urandom_range(0, 30));
          if (op == OP_JZ) depth--;
        end
        OP_PRV: begin load_op(op, 0); depth--; end
        OP_EXIT: load_op(op, 0);
        default: begin load_op(op, 0); if (op <= OP_EQ) depth--; end
      endcase
      if (depth < 0) depth = 0;
    end
    repeat (n + 3) send_beat(ACT_EXEC, $urandom);
  endtask

  initial begin
    int k;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    beats_sent = 0;
    hold_cycles = 0;
    long_hold = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: arithmetic edges, division by zero and overflow, faults, strings.
    write_string_count(5);
    load_op(OP_IMM, 32'h80000000);
    load_op(OP_IMM, 32'hFFFFFFFF);
    load_op(OP_DIV, 0);
    load_op(OP_PRV, 0);
    load_op(OP_IMM, 7);
    load_op(OP_IMM, 0);
    load_op(OP_DIV, 0);
    load_op(OP_PRS, 4);
    load_op(OP_PRS, 5);
    load_op(OP_PRS, 32'hFFFFFFFF);
    load_op(OP_STO, 26);
    repeat (12) send_beat(ACT_EXEC, 0);
    send_beat(2'd3, 32'h5A5A5A5A);
    send_beat(ACT_CLEAR, 0);
    load_op(OP_JMP, 32'hFFFFFFFF);
    load_op(32'd99, 0);
    repeat (3) send_beat(ACT_EXEC, 32'hFFFFFFFF);

    // Underflow the empty stack with an add.
    send_beat(ACT_CLEAR, 0);
    load_op(OP_ADD, 0);
    send_beat(ACT_EXEC, 0);
    send_beat(ACT_EXEC, 0);

    // Random programs across several string counts, with one long receiver hold.
    k = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_string_count(phase == 0 ? 0 : phase == 1 ? 64 : phase == 2 ? 127 : $urandom_range(1, 63));
      while (beats_sent < 450 * (phase + 1) + 100) begin
        if (phase == 1 && k == 0) begin
          long_hold = 1;
          k = 1;
        end
        if ($urandom_range(0, 15) == 0) send_beat(2'($urandom_range(0, 3)), $urandom);
        else random_program();
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d beats and checked %0d result beats over four string counts.",
             beats_sent, result_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sbe_pkg.sv
rtl/core/sbe_alu.sv
rtl/core/stack_bytecode_executor.sv
test/stack_bytecode_executor_checker.sv
test/stack_bytecode_executor_tb.sv
